>>> hdl/utf8_stream_decoder_assert.svh
// Assertion macros shared by the UTF-8 stream decoder checkers.
// Each macro expects signals named clk and rst_n in the scope of use.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define UTF8SD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define UTF8SD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/utf8sd_pkg.sv
// Shared types, constants and the window decode function of the UTF-8 decoder.
// No dependencies; used by utf8sd_assemble, utf8sd_scale and the top level.
package utf8sd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CP_W     = 21;
  localparam int unsigned OFF_W    = 29;
  localparam int unsigned PACK_W   = 32;
  localparam int unsigned OUT_W    = 56;   // 21 + 29 packed, padded to whole bytes
  localparam int unsigned OUT_PAD  = OUT_W - CP_W - OFF_W;

  // Packed-word windows per sequence length
  localparam logic [PACK_W-1:0] ASCII_LIM = 32'h0000_0080;
  localparam logic [PACK_W-1:0] WIN2_HI   = 32'h0000_DFC0;
  localparam logic [PACK_W-1:0] WIN3_LO   = 32'h00E0_807F;
  localparam logic [PACK_W-1:0] WIN3_HI   = 32'h00EF_BFC0;
  localparam logic [PACK_W-1:0] WIN4_LO   = 32'hF080_807F;
  localparam logic [PACK_W-1:0] WIN4_HI   = 32'hF7BF_BFC0;

  // Continuation bytes still expected after a lead byte
  localparam logic [1:0] REM_NONE = 2'd0;
  localparam logic [1:0] REM_ONE  = 2'd1;
  localparam logic [1:0] REM_TWO  = 2'd2;
  localparam logic [1:0] REM_THREE = 2'd3;

  localparam logic [BYTE_W-1:0] GLYPH_RESET = 8'd32;

  // One decoded character between the two stages
  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            end_of_string;
  } utf8sd_char_t;

  // Window check on a completed packed word, then join of the payload bits
  function automatic logic [CP_W-1:0] window_decode(input logic [PACK_W-1:0] p);
    logic in2;
    logic in3;
    logic in4;
    logic [CP_W-1:0] cp;
    in2 = (p < WIN2_HI);
    in3 = (p > WIN3_LO) && (p < WIN3_HI);
    in4 = (p > WIN4_LO) && (p < WIN4_HI);
    if (p < ASCII_LIM) begin
      cp = p[CP_W-1:0];
    end else if (in2) begin
      cp = {10'd0, p[12:8], p[5:0]};
    end else if (in3) begin
      cp = {5'd0, p[19:16], p[13:8], p[5:0]};
    end else if (in4) begin
      cp = {p[26:24], p[21:16], p[13:8], p[5:0]};
    end else begin
      cp = '0;
    end
    return cp;
  endfunction

endpackage

>>> hdl/utf8sd_assemble.sv
// Sequence tracking and window decode: collects bytes and registers a character.
// Depends on utf8sd_pkg.
module utf8sd_assemble (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                data_byte,
  input  logic                      last_byte,
  input  logic                      s2_ready,
  output logic                      s1_valid,
  output utf8sd_pkg::utf8sd_char_t  s1_char
);

  logic [31:0]              packed_r, packed_nxt;
  logic [1:0]               rem_r, rem_nxt;
  logic                     s1_valid_r, s1_valid_nxt;
  utf8sd_pkg::utf8sd_char_t s1_char_r, s1_char_nxt;
  logic                     adv;
  logic                     accept;
  logic                     emit;
  logic [31:0]              shifted;
  logic [1:0]               rem_dec;

  // Stage moves when empty or when the output stage takes it
  assign adv      = !s1_valid_r || s2_ready;
  assign in_ready = adv;
  assign accept   = in_valid && adv;
  assign shifted  = {packed_r[23:0], data_byte};
  assign rem_dec  = rem_r - 2'd1;

  // Next sequence state and the character that this word completes
  always_comb begin
    packed_nxt  = packed_r;
    rem_nxt     = rem_r;
    emit        = 1'b0;
    s1_char_nxt = s1_char_r;
    if (accept) begin
      if (rem_r != utf8sd_pkg::REM_NONE) begin
        // continuation: taken without checks
        packed_nxt = shifted;
        rem_nxt    = rem_dec;
        if (rem_dec == utf8sd_pkg::REM_NONE) begin
          emit                      = 1'b1;
          s1_char_nxt.code_point    = utf8sd_pkg::window_decode(shifted);
          s1_char_nxt.end_of_string = last_byte;
          packed_nxt                = '0;
        end else if (last_byte) begin
          packed_nxt = '0;
          rem_nxt    = utf8sd_pkg::REM_NONE;
        end
      end else if (!data_byte[7]) begin
        emit                      = 1'b1;
        s1_char_nxt.code_point    = {13'd0, data_byte};
        s1_char_nxt.end_of_string = last_byte;
      end else if (data_byte[7:5] == 3'b110 || data_byte[7:4] == 4'b1110 ||
                   data_byte[7:3] == 5'b11110) begin
        // lead byte opens a sequence unless the string ends here
        if (!last_byte) begin
          packed_nxt = {24'd0, data_byte};
          if (data_byte[7:5] == 3'b110) begin
            rem_nxt = utf8sd_pkg::REM_ONE;
          end else if (data_byte[7:4] == 4'b1110) begin
            rem_nxt = utf8sd_pkg::REM_TWO;
          end else begin
            rem_nxt = utf8sd_pkg::REM_THREE;
          end
        end
      end
      // stray bytes fall through: no state change, no character
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (adv) begin
      s1_valid_nxt = emit;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      packed_r   <= '0;
      rem_r      <= utf8sd_pkg::REM_NONE;
      s1_valid_r <= 1'b0;
    end else begin
      packed_r   <= packed_nxt;
      rem_r      <= rem_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    s1_char_r <= s1_char_nxt;
  end

  assign s1_valid = s1_valid_r;
  assign s1_char  = s1_char_r;

endmodule

>>> hdl/utf8sd_scale.sv
// Glyph size register, offset multiply and the output register.
// Depends on utf8sd_pkg.
module utf8sd_scale (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  input  logic [7:0]                cfg_data,
  input  logic                      s1_valid,
  input  utf8sd_pkg::utf8sd_char_t  s1_char,
  output logic                      s2_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [20:0]               code_point,
  output logic [28:0]               glyph_offset,
  output logic                      end_of_string
);

  logic [7:0]  glyph_r;
  logic        out_valid_r, out_valid_nxt;
  logic [20:0] cp_r, cp_nxt;
  logic [28:0] off_r, off_nxt;
  logic        eos_r, eos_nxt;
  logic [28:0] product;

  // 21 x 8 fits exactly in 29 bits
  assign product  = 29'(s1_char.code_point) * 29'(glyph_r);
  assign s2_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    cp_nxt        = cp_r;
    off_nxt       = off_r;
    eos_nxt       = eos_r;
    if (s2_ready) begin
      out_valid_nxt = s1_valid;
      cp_nxt        = s1_char.code_point;
      off_nxt       = product;
      eos_nxt       = s1_char.end_of_string;
    end
  end

  // Control state and the glyph size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_r     <= utf8sd_pkg::GLYPH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        glyph_r <= cfg_data;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    cp_r  <= cp_nxt;
    off_r <= off_nxt;
    eos_r <= eos_nxt;
  end

  assign out_valid     = out_valid_r;
  assign code_point    = cp_r;
  assign glyph_offset  = off_r;
  assign end_of_string = eos_r;

endmodule

>>> hdl/utf8_stream_decoder.sv
// UTF-8 stream decoder top level: byte stream in, code points and glyph offsets out.
// Depends on utf8sd_pkg, utf8sd_assemble and utf8sd_scale.
//
// Usage:
//   in_*  : one string byte per word; in_tlast marks the final byte of a string.
//   out_* : one word per decoded character: code point, glyph byte offset
//           (code point times glyph size) and, on tlast, the end-of-string flag.
//   cfg_* : glyph size in bytes; always ready, write it only while idle.
// The word that completes a character is registered in the decode stage, then in the multiply stage, before out_tvalid.
// Throughput is one byte per cycle: the decode stage and the multiply stage
// each hold one word, so bytes flow back to back while the sink keeps up.
// Continuation bytes, stray bytes and dropped partial sequences give no word.
// Reset clears the open sequence, both stages and sets the glyph size to 32.
// When the sink stalls, the output word holds and the decode stage still
// takes words until it holds a character; in_tready falls only when both stages are full.
module utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [20:0] code_point, [49:21] glyph_offset, rest zero
  output logic        out_tlast,  // end_of_string
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // glyph_bytes
);

  logic                     s1_valid;
  logic                     s2_ready;
  utf8sd_pkg::utf8sd_char_t s1_char;
  logic [20:0]              code_point;
  logic [28:0]              glyph_offset;

  assign cfg_ready = 1'b1;

  utf8sd_assemble u_assemble (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .s2_ready  (s2_ready),
    .s1_valid  (s1_valid),
    .s1_char   (s1_char)
  );

  utf8sd_scale u_scale (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .s1_valid      (s1_valid),
    .s1_char       (s1_char),
    .s2_ready      (s2_ready),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .code_point    (code_point),
    .glyph_offset  (glyph_offset),
    .end_of_string (out_tlast)
  );

  assign out_tdata = {{utf8sd_pkg::OUT_PAD{1'b0}}, glyph_offset, code_point};

endmodule

>>> hdl/utf8sd_checker.sv
// Port-level checks for the UTF-8 stream decoder, bound to the top level.
// Depends on utf8_stream_decoder_assert.svh.
`include "utf8_stream_decoder_assert.svh"

module utf8sd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tlast
);

  // A stalled result word holds
  `UTF8SD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "output word changed under stall")

  // Padding above the glyph offset stays zero
  `UTF8SD_ASSERT_NOW(a_pad_zero, out_tvalid, out_tdata[55:50] == 6'd0, "tdata padding not zero")

  // A zero code point has a zero offset
  `UTF8SD_ASSERT_NOW(a_zero_off, out_tvalid && out_tdata[20:0] == 21'd0, out_tdata[49:21] == 29'd0, "nonzero offset for zero code point")

  // A fresh result follows an accepted byte that went through the decode and multiply registers
  `UTF8SD_ASSERT_NOW(a_latency, $rose(out_tvalid), $past(in_tvalid && in_tready, 2), "result without a matching input word")

endmodule

bind utf8_stream_decoder utf8sd_checker u_utf8sd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
